// File: hdl/gpiorb_pkg.sv
package gpiorb_pkg;

  localparam int unsigned PIN_COUNT_DEF = 54;

  localparam int unsigned DATA_W        = 32;
  localparam int unsigned IDX_W         = 6;
  localparam int unsigned FSEL_WORDS    = 6;
  localparam int unsigned PINS_PER_FSEL = 10;
  localparam int unsigned FSEL_FIELD_W  = 3;
  localparam int unsigned FSEL_WORD_W   = PINS_PER_FSEL * FSEL_FIELD_W;
  localparam int unsigned FSEL_SEL_W    = $clog2(FSEL_WORDS);
  localparam int unsigned PULL_W        = 2;
  localparam int unsigned BANK_W        = 2 * DATA_W;

  localparam logic [FSEL_FIELD_W-1:0] FSEL_FIELD_MASK = 3'h7;
  localparam logic [FSEL_FIELD_W-1:0] FSEL_OUTPUT     = 3'd1;

  localparam logic [PULL_W-1:0] PULL_OFF  = 2'd0;
  localparam logic [PULL_W-1:0] PULL_DOWN = 2'd1;
  localparam logic [PULL_W-1:0] PULL_UP   = 2'd2;

  localparam logic [IDX_W-1:0] IDX_FSEL_FIRST = 6'd0;
  localparam logic [IDX_W-1:0] IDX_FSEL_LAST  = 6'd5;
  localparam logic [IDX_W-1:0] IDX_SET0       = 6'd7;
  localparam logic [IDX_W-1:0] IDX_SET1       = 6'd8;
  localparam logic [IDX_W-1:0] IDX_CLR0       = 6'd10;
  localparam logic [IDX_W-1:0] IDX_CLR1       = 6'd11;
  localparam logic [IDX_W-1:0] IDX_LEV0       = 6'd13;
  localparam logic [IDX_W-1:0] IDX_LEV1       = 6'd14;
  localparam logic [IDX_W-1:0] IDX_PULL       = 6'd37;
  localparam logic [IDX_W-1:0] IDX_PCLK0      = 6'd38;
  localparam logic [IDX_W-1:0] IDX_PCLK1      = 6'd39;

  typedef struct packed {
    logic              wr;
    logic [IDX_W-1:0]  idx;
    logic [DATA_W-1:0] data;
  } access_t;

  typedef struct packed {
    logic [DATA_W-1:0] read_data;
    logic              bad_address;
  } result_t;

endpackage

// File: hdl/gpio_register_block_top.sv
// Path: a beat accepted into the input register is committed and its result captured in
// the result register, which drives the outputs; a held, stalled result stalls the input register.
// Throughput: one bus access per cycle unless a stalled result holds it; the access is
// decoded and the register state updated in a single pass between the input register and the result register.
// Reset (rst_n, synchronous, active low): all function words zero (every pin an
// input), output latch zero, pull control and every pin's pull state off.
module gpio_register_block_top #(
  parameter int unsigned PIN_COUNT = gpiorb_pkg::PIN_COUNT_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic                              in_action,
  input  logic [gpiorb_pkg::IDX_W-1:0]      in_reg_index,
  input  logic [gpiorb_pkg::DATA_W-1:0]     in_write_data,
  input  logic [PIN_COUNT-1:0]              in_pin_levels,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic [gpiorb_pkg::DATA_W-1:0]     out_read_data,
  output logic [PIN_COUNT-1:0]              out_drive_levels,
  output logic [PIN_COUNT-1:0]              out_drive_enable,
  output logic [PIN_COUNT-1:0]              out_pull_up_pins,
  output logic [PIN_COUNT-1:0]              out_pull_down_pins,
  output logic                              out_bad_address
);

  logic                  s1_valid_r;
  gpiorb_pkg::access_t   s1_item_r;
  logic [PIN_COUNT-1:0]  s1_levels_r;
  logic                  advance;
  logic                  fire;
  gpiorb_pkg::result_t   rsp;
  logic [PIN_COUNT-1:0]  drv_lvl, drv_en, pu, pd;

  logic                  out_valid_r;
  gpiorb_pkg::result_t   out_rsp_r;
  logic [PIN_COUNT-1:0]  out_lvl_r, out_en_r, out_pu_r, out_pd_r;

  assign advance  = !out_valid_r || !out_stall;
  assign fire     = s1_valid_r && advance;
  assign in_stall = s1_valid_r && !advance;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (!in_stall) begin
      s1_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      s1_item_r.wr   <= in_action;
      s1_item_r.idx  <= in_reg_index;
      s1_item_r.data <= in_write_data;
      s1_levels_r    <= in_pin_levels;
    end
  end

  gpiorb_regs #(
    .PIN_COUNT(PIN_COUNT)
  ) u_regs (
    .clk         (clk),
    .rst_n       (rst_n),
    .commit      (fire),
    .item        (s1_item_r),
    .levels      (s1_levels_r),
    .rsp         (rsp),
    .drive_levels(drv_lvl),
    .drive_enable(drv_en),
    .pull_up     (pu),
    .pull_down   (pd)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      out_rsp_r <= rsp;
      out_lvl_r <= drv_lvl;
      out_en_r  <= drv_en;
      out_pu_r  <= pu;
      out_pd_r  <= pd;
    end
  end

  assign out_valid          = out_valid_r;
  assign out_read_data      = out_rsp_r.read_data;
  assign out_bad_address    = out_rsp_r.bad_address;
  assign out_drive_levels   = out_lvl_r;
  assign out_drive_enable   = out_en_r;
  assign out_pull_up_pins   = out_pu_r;
  assign out_pull_down_pins = out_pd_r;

`ifndef SYNTHESIS
  a_bad_reads_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_bad_address |-> out_read_data == '0)
    else $error("bad address beat carries nonzero read data");

  a_pull_disjoint: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_pull_up_pins & out_pull_down_pins) == '0)
    else $error("pin reported as both pull-up and pull-down");

  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> out_valid_r && out_stall && s1_valid_r)
    else $error("input stalled without a blocked result");

  a_write_reads_zero: assert property (@(posedge clk) disable iff (!rst_n)
    fire && s1_item_r.wr |=> out_valid && out_read_data == '0)
    else $error("write beat returned nonzero read data");
`endif

endmodule

// File: hdl/gpiorb_regs.sv
module gpiorb_regs #(
  parameter int unsigned PIN_COUNT = gpiorb_pkg::PIN_COUNT_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 commit,
  input  gpiorb_pkg::access_t  item,
  input  logic [PIN_COUNT-1:0] levels,
  output gpiorb_pkg::result_t  rsp,
  output logic [PIN_COUNT-1:0] drive_levels,
  output logic [PIN_COUNT-1:0] drive_enable,
  output logic [PIN_COUNT-1:0] pull_up,
  output logic [PIN_COUNT-1:0] pull_down
);

  logic [gpiorb_pkg::FSEL_WORD_W-1:0] fsel_r    [gpiorb_pkg::FSEL_WORDS];
  logic [gpiorb_pkg::FSEL_WORD_W-1:0] fsel_nxt  [gpiorb_pkg::FSEL_WORDS];
  logic [gpiorb_pkg::FSEL_WORD_W-1:0] fsel_mask [gpiorb_pkg::FSEL_WORDS];
  logic [PIN_COUNT-1:0]               latch_r, latch_nxt;
  logic [gpiorb_pkg::PULL_W-1:0]      pctl_r, pctl_nxt;
  logic [gpiorb_pkg::PULL_W-1:0]      pstate_r   [PIN_COUNT];
  logic [gpiorb_pkg::PULL_W-1:0]      pstate_nxt [PIN_COUNT];
  logic                               bank_sel;
  logic [gpiorb_pkg::BANK_W-1:0]      data_wide;
  logic [gpiorb_pkg::BANK_W-1:0]      lev_wide;
  logic [PIN_COUNT-1:0]               bank_mask;
  logic [gpiorb_pkg::DATA_W-1:0]      lev_word;
  logic [gpiorb_pkg::FSEL_SEL_W-1:0]  fsel_sel;

  always_comb begin
    for (int k = 0; k < int'(gpiorb_pkg::FSEL_WORDS); k++) begin
      for (int j = 0; j < int'(gpiorb_pkg::PINS_PER_FSEL); j++) begin
        if (k * int'(gpiorb_pkg::PINS_PER_FSEL) + j < int'(PIN_COUNT)) begin
          fsel_mask[k][j*gpiorb_pkg::FSEL_FIELD_W +: gpiorb_pkg::FSEL_FIELD_W] =
            gpiorb_pkg::FSEL_FIELD_MASK;
        end else begin
          fsel_mask[k][j*gpiorb_pkg::FSEL_FIELD_W +: gpiorb_pkg::FSEL_FIELD_W] = '0;
        end
      end
    end
  end

  assign bank_sel  = (item.idx == gpiorb_pkg::IDX_SET1) || (item.idx == gpiorb_pkg::IDX_CLR1) ||
                     (item.idx == gpiorb_pkg::IDX_LEV1) || (item.idx == gpiorb_pkg::IDX_PCLK1);
  assign data_wide = bank_sel ? {item.data, {gpiorb_pkg::DATA_W{1'b0}}}
                              : {{gpiorb_pkg::DATA_W{1'b0}}, item.data};
  assign bank_mask = data_wide[PIN_COUNT-1:0];
  assign lev_wide  = gpiorb_pkg::BANK_W'(levels);
  assign lev_word  = bank_sel ? lev_wide[gpiorb_pkg::BANK_W-1:gpiorb_pkg::DATA_W]
                              : lev_wide[gpiorb_pkg::DATA_W-1:0];
  assign fsel_sel  = item.idx[gpiorb_pkg::FSEL_SEL_W-1:0];

  always_comb begin
    fsel_nxt        = fsel_r;
    latch_nxt       = latch_r;
    pctl_nxt        = pctl_r;
    pstate_nxt      = pstate_r;
    rsp.read_data   = '0;
    rsp.bad_address = 1'b0;
    unique case (item.idx) inside
      [gpiorb_pkg::IDX_FSEL_FIRST:gpiorb_pkg::IDX_FSEL_LAST]: begin
        if (item.wr) begin
          fsel_nxt[fsel_sel] = item.data[gpiorb_pkg::FSEL_WORD_W-1:0] & fsel_mask[fsel_sel];
        end else begin
          rsp.read_data = gpiorb_pkg::DATA_W'(fsel_r[fsel_sel]);
        end
      end
      gpiorb_pkg::IDX_SET0, gpiorb_pkg::IDX_SET1: begin
        if (item.wr) begin
          latch_nxt = latch_r | bank_mask;
        end
      end
      gpiorb_pkg::IDX_CLR0, gpiorb_pkg::IDX_CLR1: begin
        if (item.wr) begin
          latch_nxt = latch_r & ~bank_mask;
        end
      end
      gpiorb_pkg::IDX_LEV0, gpiorb_pkg::IDX_LEV1: begin
        if (!item.wr) begin
          rsp.read_data = lev_word;
        end
      end
      gpiorb_pkg::IDX_PULL: begin
        if (item.wr) begin
          pctl_nxt = item.data[gpiorb_pkg::PULL_W-1:0];
        end else begin
          rsp.read_data = gpiorb_pkg::DATA_W'(pctl_r);
        end
      end
      gpiorb_pkg::IDX_PCLK0, gpiorb_pkg::IDX_PCLK1: begin
        if (item.wr) begin
          for (int p = 0; p < int'(PIN_COUNT); p++) begin
            if (bank_mask[p]) begin
              pstate_nxt[p] = pctl_r;
            end
          end
        end
      end
      default: begin
        rsp.bad_address = 1'b1;
      end
    endcase
  end

  assign drive_levels = latch_nxt;

  for (genvar p = 0; p < PIN_COUNT; p++) begin : g_pin
    localparam int unsigned W  = p / gpiorb_pkg::PINS_PER_FSEL;
    localparam int unsigned SH = (p % gpiorb_pkg::PINS_PER_FSEL) * gpiorb_pkg::FSEL_FIELD_W;
    assign drive_enable[p] =
      (fsel_nxt[W][SH +: gpiorb_pkg::FSEL_FIELD_W] == gpiorb_pkg::FSEL_OUTPUT);
    assign pull_up[p]   = (pstate_nxt[p] == gpiorb_pkg::PULL_UP);
    assign pull_down[p] = (pstate_nxt[p] == gpiorb_pkg::PULL_DOWN);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k < int'(gpiorb_pkg::FSEL_WORDS); k++) begin
        fsel_r[k] <= '0;
      end
      latch_r <= '0;
      pctl_r  <= gpiorb_pkg::PULL_OFF;
      for (int p = 0; p < int'(PIN_COUNT); p++) begin
        pstate_r[p] <= gpiorb_pkg::PULL_OFF;
      end
    end else if (commit) begin
      fsel_r   <= fsel_nxt;
      latch_r  <= latch_nxt;
      pctl_r   <= pctl_nxt;
      pstate_r <= pstate_nxt;
    end
  end

endmodule
